[hdl/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the multidimensional Simpson accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

  localparam int SAMPLE_W  = 32;  // signed Q16.16 sample
  localparam int SUM_W     = 64;  // accumulator and result width
  localparam int SCALE_W   = 32;  // unsigned Q16.16 scale
  localparam int PROD_W    = SUM_W + SCALE_W;
  localparam int FRAC_W    = 16;
  localparam int DIMS_W    = 3;   // dims_in_use register width
  localparam int IV_W      = 11;  // interval count register width
  localparam int NUM_IV    = 4;   // interval count registers
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int EXP_W     = 5;   // weight exponent, up to 2 per dimension, 7 dimensions
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS  = 3'd0,
    REG_IV0   = 3'd1,
    REG_IV1   = 3'd2,
    REG_IV2   = 3'd3,
    REG_IV3   = 3'd4,
    REG_SCALE = 3'd5
  } cfg_reg_t;

  // one classified sample between front and back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [EXP_W-1:0]           shift;
    logic                       last;
  } msa_item_t;

  // finished weighted sum handed to the scaler
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
  } msa_fin_t;

endpackage

`default_nettype wire

[hdl/msa_front.sv]
// ----------------------------------------------------------------------------
// msa_front
// Grid index counters: assigns each sample its Simpson weight exponent and
// flags the last grid point.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_front import msa_pkg::*; #(
  parameter int MAX_DIMS      = 4,
  parameter int MAX_INTERVALS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_W-1:0]            in_sample,
  input  wire logic [DIMS_W-1:0]              dims_cfg,
  input  wire logic [NUM_IV-1:0][IV_W-1:0]    intervals_cfg,
  output logic                                push,
  output msa_item_t                           push_item,
  input  wire logic                           q_full
);

  localparam int TOP    = MAX_INTERVALS - (MAX_INTERVALS % 2);
  localparam int IDX_W  = $clog2(TOP + 1);
  localparam int CMP_W  = (IDX_W > IV_W) ? IDX_W : IV_W;
  localparam int DCNT_W = $clog2(MAX_DIMS + 1);
  localparam int DC_W   = (DCNT_W > DIMS_W) ? DCNT_W : DIMS_W;

  logic [IDX_W-1:0] grid_index      [MAX_DIMS];
  logic [IDX_W-1:0] grid_index_next [MAX_DIMS];
  logic [IDX_W-1:0] n_end           [MAX_DIMS];
  logic [MAX_DIMS-1:0] act;
  logic [MAX_DIMS-1:0] at_end;
  logic [DC_W-1:0]  dims_eff;
  logic [EXP_W-1:0] shift;
  logic             last;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dims_eff = DC_W'(dims_cfg);
    if (dims_eff == '0) begin
      dims_eff = DC_W'(1);
    end else if (dims_eff > DC_W'(MAX_DIMS)) begin
      dims_eff = DC_W'(MAX_DIMS);
    end
  end

  // per-dimension end index and weight
  always_comb begin
    logic [CMP_W-1:0] nv;
    nv    = '0;
    shift = '0;
    last  = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < NUM_IV) begin
        nv = CMP_W'(intervals_cfg[(d < NUM_IV) ? d : 0]) & ~CMP_W'(1);
      end else begin
        nv = CMP_W'(TOP);
      end
      if (nv < CMP_W'(2)) begin
        nv = CMP_W'(2);
      end else if (nv > CMP_W'(TOP)) begin
        nv = CMP_W'(TOP);
      end
      n_end[d]  = IDX_W'(nv);
      act[d]    = DC_W'(d) < dims_eff;
      at_end[d] = grid_index[d] >= n_end[d];
      if (act[d]) begin
        if (grid_index[d] != '0 && !at_end[d]) begin
          shift = shift + (grid_index[d][0] ? EXP_W'(2) : EXP_W'(1));
        end
        if (!at_end[d]) begin
          last = 1'b0;
        end
      end
    end
  end

  // odometer advance, fastest dimension is the highest active one
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int k = MAX_DIMS - 1; k >= 0; k--) begin
      grid_index_next[k] = grid_index[k];
      if (last) begin
        grid_index_next[k] = '0;
      end else if (act[k] && carry) begin
        if (at_end[k]) begin
          grid_index_next[k] = '0;
        end else begin
          grid_index_next[k] = grid_index[k] + IDX_W'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        grid_index[d] <= '0;
      end
    end else if (accept) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        grid_index[d] <= grid_index_next[d];
      end
    end
  end

  assign push             = accept;
  assign push_item.sample = in_sample;
  assign push_item.shift  = shift;
  assign push_item.last   = last;

endmodule

`default_nettype wire

[hdl/msa_queue.sv]
// ----------------------------------------------------------------------------
// msa_queue
// Short FIFO of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_queue import msa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire msa_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           q_valid,
  output msa_item_t      q_item
);

  msa_item_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == (QPTR_W + 1)'(QDEPTH);
  assign q_valid = count != '0;
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/msa_accum.sv]
// ----------------------------------------------------------------------------
// msa_accum
// Saturating 64-bit accumulator of shifted samples; hands the sum of a
// finished grid to the scaler and clears.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_accum import msa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire msa_item_t q_item,
  output logic           pop,
  output logic           fin_valid,
  output msa_fin_t       fin,
  input  wire logic      fin_ready
);

  logic signed [SUM_W-1:0] weighted_sum;
  logic                    overflow_seen;
  logic [SUM_W-1:0]        term;
  logic [SUM_W:0]          sum_wide;
  logic                    sat;
  logic [SUM_W-1:0]        sum_next;
  logic                    fin_open;

  assign fin_open = !fin_valid || fin_ready;
  assign pop      = q_valid && (!q_item.last || fin_open);

  assign term     = {{(SUM_W - SAMPLE_W){q_item.sample[SAMPLE_W-1]}}, q_item.sample}
                    << q_item.shift;
  assign sum_wide = {weighted_sum[SUM_W-1], weighted_sum} + {term[SUM_W-1], term};
  assign sat      = sum_wide[SUM_W] != sum_wide[SUM_W-1];

  always_comb begin
    sum_next = sum_wide[SUM_W-1:0];
    if (sat) begin
      sum_next = term[SUM_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_sum  <= '0;
      overflow_seen <= 1'b0;
      fin_valid     <= 1'b0;
    end else begin
      if (pop && q_item.last) begin
        weighted_sum  <= '0;
        overflow_seen <= 1'b0;
        fin_valid     <= 1'b1;
      end else begin
        if (pop) begin
          weighted_sum  <= sum_next;
          overflow_seen <= overflow_seen | sat;
        end
        if (fin_valid && fin_ready) begin
          fin_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      fin.sum <= sum_next;
      fin.ovf <= overflow_seen | sat;
    end
  end

endmodule

`default_nettype wire

[hdl/msa_scale.sv]
// ----------------------------------------------------------------------------
// msa_scale
// Elastic pipeline: magnitude, two 32x32 partial products, rounded sum,
// saturation and sign, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msa_scale import msa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fin_valid,
  input  wire msa_fin_t           fin,
  output logic                    fin_ready,
  input  wire logic [SCALE_W-1:0] scale,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [SUM_W-1:0]        integral,
  output logic                    saturated
);

  localparam int HALF = SUM_W / 2;

  // magnitude stage
  logic             mag_valid;
  logic [SUM_W-1:0] mag;
  logic             mag_neg;
  logic             mag_ovf;
  // product stage
  logic                       prd_valid;
  logic [HALF+SCALE_W-1:0]    p_lo;
  logic [HALF+SCALE_W-1:0]    p_hi;
  logic                       prd_neg;
  logic                       prd_ovf;
  // rounded total stage
  logic              tot_valid;
  logic [PROD_W-1:0] total;
  logic              tot_neg;
  logic              tot_ovf;

  logic out_rdy, tot_rdy, prd_rdy, mag_rdy;
  logic [SUM_W-1:0] r;
  logic             hi_sat;
  logic [SUM_W-1:0] res;
  logic             res_sat;

  assign out_rdy   = !out_valid || out_ready;
  assign tot_rdy   = !tot_valid || out_rdy;
  assign prd_rdy   = !prd_valid || tot_rdy;
  assign mag_rdy   = !mag_valid || prd_rdy;
  assign fin_ready = mag_rdy;

  assign r      = total[SUM_W+FRAC_W-1:FRAC_W];
  assign hi_sat = |total[PROD_W-1:SUM_W+FRAC_W];

  always_comb begin
    res     = r;
    res_sat = 1'b0;
    if (tot_neg) begin
      if (hi_sat || (r[SUM_W-1] && |r[SUM_W-2:0])) begin
        res     = {1'b1, {(SUM_W - 1){1'b0}}};
        res_sat = 1'b1;
      end else begin
        res = -r;
      end
    end else if (hi_sat || r[SUM_W-1]) begin
      res     = {1'b0, {(SUM_W - 1){1'b1}}};
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
      prd_valid <= 1'b0;
      tot_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mag_rdy) begin
        mag_valid <= fin_valid;
      end
      if (prd_rdy) begin
        prd_valid <= mag_valid;
      end
      if (tot_rdy) begin
        tot_valid <= prd_valid;
      end
      if (out_rdy) begin
        out_valid <= tot_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mag_rdy && fin_valid) begin
      mag_neg <= fin.sum[SUM_W-1];
      mag     <= fin.sum[SUM_W-1] ? -fin.sum : fin.sum;
      mag_ovf <= fin.ovf;
    end
    if (prd_rdy && mag_valid) begin
      p_lo    <= (HALF + SCALE_W)'(mag[HALF-1:0]) * (HALF + SCALE_W)'(scale);
      p_hi    <= (HALF + SCALE_W)'(mag[SUM_W-1:HALF]) * (HALF + SCALE_W)'(scale);
      prd_neg <= mag_neg;
      prd_ovf <= mag_ovf;
    end
    if (tot_rdy && prd_valid) begin
      total   <= PROD_W'(p_lo) + {p_hi, {HALF{1'b0}}}
                 + PROD_W'(1 << (FRAC_W - 1));
      tot_neg <= prd_neg;
      tot_ovf <= prd_ovf;
    end
    if (out_rdy && tot_valid) begin
      integral  <= res;
      saturated <= res_sat | tot_ovf;
    end
  end

endmodule

`default_nettype wire

[hdl/multidim_simpson_accumulator.sv]
// ----------------------------------------------------------------------------
// multidim_simpson_accumulator
// Composite Simpson rule over up to MAX_DIMS dimensions: weights streamed
// samples by shift, accumulates with saturation, scales on the last point.
// ----------------------------------------------------------------------------
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata[31:0] sample
//   m_axis    out  m_axis_tvalid/tready      tdata[63:0] integral, tuser saturated
//   cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One sample per cycle while the queue has room; the last sample's sum passes the
// queue, accumulator, magnitude, partial products, rounded sum, output registers.
// The 4-deep queue decouples sample intake from the accumulator; a stalled
// output only holds the accumulator on a last point, other samples keep going.
// Synchronous reset clears counters, accumulator and all valid flags; no
// clearing pass. Config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module multidim_simpson_accumulator import msa_pkg::*; #(
  parameter int MAX_DIMS      = 4,
  parameter int MAX_INTERVALS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SUM_W-1:0]           m_axis_tdata,   // [63:0] integral
  output logic                       m_axis_tuser,   // [0] saturated
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIMS_W-1:0]           dims_in_use;
  logic [NUM_IV-1:0][IV_W-1:0] intervals;
  logic [SCALE_W-1:0]          scale;

  logic      push;
  msa_item_t push_item;
  logic      q_full;
  logic      q_valid;
  msa_item_t q_item;
  logic      pop;
  logic      fin_valid;
  logic      fin_ready;
  msa_fin_t  fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= DIMS_W'(1);
      for (int i = 0; i < NUM_IV; i++) begin
        intervals[i] <= IV_W'(2);
      end
      scale <= SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIMS:  dims_in_use  <= cfg_data[DIMS_W-1:0];
        REG_IV0:   intervals[0] <= cfg_data[IV_W-1:0];
        REG_IV1:   intervals[1] <= cfg_data[IV_W-1:0];
        REG_IV2:   intervals[2] <= cfg_data[IV_W-1:0];
        REG_IV3:   intervals[3] <= cfg_data[IV_W-1:0];
        REG_SCALE: scale        <= cfg_data[SCALE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  msa_front #(
    .MAX_DIMS      (MAX_DIMS),
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_sample     (s_axis_tdata),
    .dims_cfg      (dims_in_use),
    .intervals_cfg (intervals),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  msa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  msa_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  msa_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .scale     (scale),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .integral  (m_axis_tdata),
    .saturated (m_axis_tuser)
  );

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multidimensional Simpson accumulator: streams
// Q16.16 samples over configured grids, predicts each weighted, scaled and
// rounded integral in a local model, and compares every result transfer.
// ----------------------------------------------------------------------------

module tb;
  import msa_pkg::*;

  localparam int DIM_LIMIT     = 4;
  localparam int SPAN_LIMIT    = 1024;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_PAUSE   = 16;   // covers pipeline depth plus input queue
  localparam int RANDOM_TARGET = 520;
  localparam int GRID_CAP      = 150;

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_CODE = 3'd7;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [SUM_W-1:0] integral;
    logic             saturated;
  } integral_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SUM_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  multidim_simpson_accumulator #(
    .MAX_DIMS(DIM_LIMIT),
    .MAX_INTERVALS(SPAN_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // local copy of registers and integration state
  logic [DIMS_W-1:0]       dims_reg;
  logic [IV_W-1:0]         iv_reg [NUM_IV];
  logic [SCALE_W-1:0]      scale_reg;
  logic [IV_W-1:0]         grid_pos [NUM_IV];
  logic signed [SUM_W-1:0] run_sum;
  logic                    run_ovf;

  integral_t pending_integrals [$];

  int  errors;
  int  samples_sent;
  int  integrals_checked;
  int  settings_used;
  int  quiet_cycles;
  bit  tx_gaps;
  bit  rx_stalls;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic int dims_from(input logic [DIMS_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_LIMIT) return DIM_LIMIT;
    return int'(raw);
  endfunction

  function automatic logic [IV_W-1:0] span_from(input logic [IV_W-1:0] raw);
    logic [IV_W-1:0] n;
    n = {raw[IV_W-1:1], 1'b0};
    if (n < 2) n = 2;
    if (n > SPAN_LIMIT) n = SPAN_LIMIT;
    return n;
  endfunction

  function automatic longint points_for(input logic [DIMS_W-1:0] dr,
                                        input logic [IV_W-1:0] raw [NUM_IV]);
    longint total;
    total = 1;
    for (int d = 0; d < dims_from(dr); d++) total *= longint'(span_from(raw[d])) + 1;
    return total;
  endfunction

  // sum * scale / 2^16, rounded half away from zero, saturated to 64 bits
  function automatic integral_t scaled_result(input logic signed [SUM_W-1:0] total,
                                              input logic [SCALE_W-1:0] k);
    logic [SUM_W-1:0] mag;
    logic [127:0]     prod;
    integral_t        r;
    mag  = total[SUM_W-1] ? -total : total;
    prod = (128'(mag) * 128'(k) + 128'h8000) >> FRAC_W;
    r.saturated = 1'b0;
    if (total[SUM_W-1]) begin
      if (prod > 128'(SUM_MIN)) begin
        r.integral  = SUM_MIN;
        r.saturated = 1'b1;
      end else begin
        r.integral = -prod[SUM_W-1:0];
      end
    end else if (prod > 128'(SUM_MAX)) begin
      r.integral  = SUM_MAX;
      r.saturated = 1'b1;
    end else begin
      r.integral = prod[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic void clear_integration();
    for (int d = 0; d < NUM_IV; d++) grid_pos[d] = '0;
    run_sum = '0;
    run_ovf = 1'b0;
  endfunction

  function automatic void note_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DIMS:  dims_reg  = data[DIMS_W-1:0];
      REG_IV0:   iv_reg[0] = data[IV_W-1:0];
      REG_IV1:   iv_reg[1] = data[IV_W-1:0];
      REG_IV2:   iv_reg[2] = data[IV_W-1:0];
      REG_IV3:   iv_reg[3] = data[IV_W-1:0];
      REG_SCALE: scale_reg = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] value);
    int                      nd;
    int                      e;
    bit                      at_end;
    logic [IV_W-1:0]         n;
    logic signed [SUM_W-1:0] term;
    logic [SUM_W:0]          acc;
    integral_t               res;
    nd = dims_from(dims_reg);
    e = 0;
    at_end = 1'b1;
    for (int d = 0; d < nd; d++) begin
      n = span_from(iv_reg[d]);
      // interior points weigh 4 when odd, 2 when even; ends and overruns weigh 1
      if (grid_pos[d] != 0 && grid_pos[d] < n) e += grid_pos[d][0] ? 2 : 1;
      if (grid_pos[d] < n) at_end = 1'b0;
    end
    term = value;
    term = term <<< e;
    acc = {run_sum[SUM_W-1], run_sum} + {term[SUM_W-1], term};
    if (acc[SUM_W] != acc[SUM_W-1]) begin
      run_sum = acc[SUM_W] ? SUM_MIN : SUM_MAX;
      run_ovf = 1'b1;
    end else begin
      run_sum = acc[SUM_W-1:0];
    end
    if (at_end) begin
      res = scaled_result(run_sum, scale_reg);
      res.saturated |= run_ovf;
      pending_integrals.push_back(res);
      clear_integration();
    end else begin
      for (int d = nd - 1; d >= 0; d--) begin
        if (grid_pos[d] >= span_from(iv_reg[d])) begin
          grid_pos[d] = '0;
        end else begin
          grid_pos[d] = grid_pos[d] + 1'b1;
          break;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4, 5: return SAMPLE_W'($signed($urandom_range(0, 'h3FFFF)) - 'h1FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = tx_gaps ? pick_wait() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb_sample(value);
    samples_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    note_register(idx, data);
    @(posedge clk);
  endtask

  // hold the sample stream until every integral has come back and the
  // pipeline has had time to empty of samples that produce nothing
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_integrals.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // junk in the unused upper bits of each write must be dropped
  task automatic program_grid(input logic [DIMS_W-1:0] dr,
                              input logic [IV_W-1:0] raw [NUM_IV],
                              input logic [SCALE_W-1:0] k);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[DIMS_W-1:0] = dr;
    cfg_write(REG_DIMS, word);
    word = $urandom;
    word[IV_W-1:0] = raw[0];
    cfg_write(REG_IV0, word);
    word = $urandom;
    word[IV_W-1:0] = raw[1];
    cfg_write(REG_IV1, word);
    word = $urandom;
    word[IV_W-1:0] = raw[2];
    cfg_write(REG_IV2, word);
    word = $urandom;
    word[IV_W-1:0] = raw[3];
    cfg_write(REG_IV3, word);
    cfg_write(REG_SCALE, k);
    settings_used++;
  endtask

  task automatic run_grid(input logic [DIMS_W-1:0] dr,
                          input logic [IV_W-1:0] raw [NUM_IV],
                          input logic [SCALE_W-1:0] k, input int count);
    wait_drained();
    program_grid(dr, raw, k);
    for (int i = 0; i < count; i++) send_sample(pick_sample());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // one dimension, two intervals, unit scale straight out of reset
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h1234_5678);
  endtask

  task automatic test_rounding_ties();
    wait_drained();
    cfg_write(REG_SCALE, 32'h0000_8000);
    send_sample(32'h0000_0001);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    wait_drained();
    cfg_write(REG_SCALE, 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
  endtask

  task automatic test_register_clamping();
    wait_drained();
    cfg_write(REG_PAST_END, 32'hFFFF_FFFF);
    cfg_write(REG_TOP_CODE, $urandom);
    cfg_write(REG_DIMS, 32'hFFFF_FFF8);      // zero dims acts as one
    cfg_write(REG_IV0, 32'h0000_0003);       // odd count drops its low bit
    cfg_write(REG_SCALE, 32'h0001_0000);
    send_sample(32'h0001_0000);
    send_sample(32'hFFFF_0000);
    send_sample(32'h0000_8000);
  endtask

  task automatic test_shrink_mid_integral();
    wait_drained();
    cfg_write(REG_DIMS, 32'h0000_0001);
    cfg_write(REG_IV0, 32'h0000_0006);
    for (int i = 0; i < 5; i++) send_sample(32'h0000_0100 << i);
    // index now sits past the new end: weight 1 and closes the integral
    wait_drained();
    cfg_write(REG_IV0, 32'h0000_0002);
    send_sample(32'h8000_0001);
  endtask

  task automatic test_config_extremes();
    logic [IV_W-1:0] raw [NUM_IV];
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    raw = '{11'd2, 11'd3, 11'd1, 11'd0};
    run_grid(3'd7, raw, 32'h0000_0000, 81);
    run_grid(3'd4, raw, 32'hFFFF_FFFF, 81);
    tx_gaps = 1'b0;
    // oversized count clamps to the top; stop part way and shrink to close
    raw = '{11'd2047, 11'd1024, 11'd1024, 11'd1024};
    run_grid(3'd1, raw, $urandom, 40);
    wait_drained();
    cfg_write(REG_IV0, 32'h0000_0002);
    send_sample(pick_sample());
  endtask

  task automatic test_random_grids();
    logic [IV_W-1:0]    raw [NUM_IV];
    logic [DIMS_W-1:0]  dr;
    logic [SCALE_W-1:0] k;
    int                 pts;
    int                 count;
    int                 tries;
    int                 streamed;
    streamed = 0;
    while (streamed < RANDOM_TARGET) begin
      tries = 0;
      do begin
        dr = $urandom_range(0, 7);
        for (int d = 0; d < NUM_IV; d++) begin
          raw[d] = $urandom_range(0, 9);
          if ($urandom_range(0, 3) == 0) raw[d][IV_W-1:4] = $urandom;
        end
        tries++;
      end while (points_for(dr, raw) > GRID_CAP && tries < 8);
      if (points_for(dr, raw) > GRID_CAP)
        for (int d = 0; d < NUM_IV; d++) raw[d] = 11'd2;
      pts = int'(points_for(dr, raw));
      case ($urandom_range(0, 3))
        0: k = $urandom;
        1: k = 32'h0001_0000;
        2: k = $urandom_range(0, 'h3FFFF);
        default: k = 32'hFFFF_FFFF;
      endcase
      count = $urandom_range(1, 3) * pts;
      // sometimes stop inside an integral so the next grid inherits the state
      if ($urandom_range(0, 4) == 0) count += $urandom_range(1, pts - 1);
      if (count > RANDOM_TARGET - streamed) count = RANDOM_TARGET - streamed;
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
        cfg_write($urandom_range(0, 1) ? REG_PAST_END : REG_TOP_CODE, $urandom);
      end
      run_grid(dr, raw, k, count);
      streamed += count;
    end
  endtask

  // ---------------------------------------------------------------- checks

  initial begin : result_sink
    int hold;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0) hold = pick_wait();
      end
    end
  end

  always @(posedge clk) begin : result_check
    integral_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_integrals.size() == 0) begin
        $error("unexpected result transfer: integral %h saturated %b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_integrals.pop_front();
        integrals_checked++;
        if (m_axis_tdata !== want.integral) begin
          $error("integral mismatch: expected %h, got %h", want.integral, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.saturated) begin
          $error("saturated mismatch: expected %b, got %b", want.saturated, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles, %0d integrals still pending",
             QUIET_LIMIT, pending_integrals.size());
      $display("multidim_simpson_accumulator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_DIMS;
    cfg_data      <= '0;
    errors            = 0;
    samples_sent      = 0;
    integrals_checked = 0;
    settings_used     = 0;
    quiet_cycles      = 0;
    tx_gaps           = 1'b0;
    rx_stalls         = 1'b0;
    dims_reg  = 3'd1;
    for (int d = 0; d < NUM_IV; d++) iv_reg[d] = 11'd2;
    scale_reg = 32'h0001_0000;
    clear_integration();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_rounding_ties();
    test_register_clamping();
    test_shrink_mid_integral();
    test_config_extremes();
    test_random_grids();

    wait_drained();
    $display("%0d samples streamed, %0d integrals compared over %0d grid settings",
             samples_sent, integrals_checked, settings_used);
    $display("covered reset defaults, rounding ties, clamped registers, shrink in flight,");
    $display("4-D grids, an oversized interval count, random gaps and stalls on both streams");
    if (errors == 0) begin
      $display("multidim_simpson_accumulator regression: pass");
    end else begin
      $display("multidim_simpson_accumulator regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/msa_pkg.sv
hdl/msa_front.sv
hdl/msa_queue.sv
hdl/msa_accum.sv
hdl/msa_scale.sv
hdl/multidim_simpson_accumulator.sv
test/tb.sv
